FILE: hw/rtl/lvn_pkg.sv
`timescale 1ns / 1ps
package lvn_pkg;
   localparam logic [31:0] PHI_Q32 = 32'd2654435388;
   localparam logic [8:0]  PRIME_X = 9'd173;
   localparam logic [8:0]  PRIME_Y = 9'd263;
   localparam logic [8:0]  PRIME_Z = 9'd337;

   typedef logic signed [34:0] wgt_type;
   typedef logic signed [17:0] dwt_type;
   typedef logic signed [27:0] mid_type;
   typedef logic signed [63:0] acc_type;
endpackage

FILE: hw/rtl/lvn_ram.sv
`timescale 1ns / 1ps
module lvn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rd_data = rdata_ff;
endmodule

FILE: hw/rtl/lattice_value_noise_3d.sv
`timescale 1ns / 1ps
// 3-D value noise with analytic gradient, quadratic B-spline blend.
// Input beats are taken on start while busy is low. A beat with req_action low
// writes req_entry_value to table entry req_entry_index in the same cycle and
// yields no result; the block stays ready (an index beyond the table is dropped).
// A beat with req_action high evaluates at (req_pos_x, req_pos_y, req_pos_z).
// Busy stays high through cell hashing via one 32x32 multiplier and weight
// setup, then reading the single-port table one entry per cycle for the 3x3x3
// lattice neighbourhood, then draining the x, y and z blend stages.
// The result beat is shown on rsp_* for one cycle with rsp_strobe high, in the
// first cycle with busy low again; the next beat may be taken in that same
// cycle; table writes are taken every cycle while busy is low.
// The receiver cannot stall: a result is present for exactly one cycle.
// Reset returns the control to idle and drops any evaluation in flight; the
// table keeps its contents and every entry must be written before it is read.
module lattice_value_noise_3d import lvn_pkg::*; #(
   parameter int TABLE_DEPTH = 512,
   parameter int FRAC_BITS   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_action,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [8:0]         req_entry_index,
   input  logic [15:0]        req_entry_value,
   output logic               rsp_strobe,
   output logic [15:0]        rsp_noise_value,
   output logic signed [17:0] rsp_grad_x,
   output logic signed [17:0] rsp_grad_y,
   output logic signed [17:0] rsp_grad_z
);
   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int UP   = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
   localparam int DN   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam int HALF = (1 << UP) >> 1;
   localparam logic [15:0] DEP = 16'(TABLE_DEPTH);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   function automatic logic [16:0] frac_q(input logic [31:0] p);
      logic [40:0] t;
      t = 41'(p) & 41'((64'd1 << FRAC_BITS) - 64'd1);
      t = ((t + 41'(HALF)) >> UP) << DN;
      return t[16:0];
   endfunction

   function automatic logic [31:0] cell_of(input logic signed [31:0] p);
      return 32'(p >>> FRAC_BITS);
   endfunction

   function automatic logic [AW-1:0] wrap_idx(input logic [9:0] s);
      logic [15:0] r;
      r = 16'(s);
      for (int b = 3; b >= 0; b--) begin
         if (r >= (DEP << b)) begin
            r = r - (DEP << b);
         end
      end
      return r[AW-1:0];
   endfunction

   function automatic acc_type rnd(input acc_type s, input int k);
      return (s + (acc_type'(1) <<< (k - 1))) >>> k;
   endfunction

   function automatic logic [15:0] sat16(input acc_type r);
      if (r < 0) begin
         return 16'd0;
      end else if (r > 64'sd65535) begin
         return 16'hFFFF;
      end
      return r[15:0];
   endfunction

   function automatic logic [17:0] sat18(input acc_type r);
      if (r < -64'sd131072) begin
         return 18'h20000;
      end else if (r > 64'sd131071) begin
         return 18'h1FFFF;
      end
      return r[17:0];
   endfunction

   // control
   logic [1:0] state_ff, state_in;
   logic [1:0] sa_ff, sa_in, sk_ff, sk_in;
   logic       bv_ff, bv_in;
   logic [1:0] rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;
   logic       p1v_ff, p1v_in, pm1v_ff, pm1v_in, r1v_ff, r1v_in, m2v_ff, m2v_in;
   logic       r2v_ff, r2v_in, m3v_ff, m3v_in, fv_ff, fv_in, rsp_strobe_ff, rsp_strobe_in;

   // setup
   logic [31:0] cell_ff [3], cell_in [3];
   logic [16:0] fq_ff [3], fq_in [3];
   logic [31:0] fr_ff, fr_in;
   logic [33:0] sq_ff, sq_in;
   logic [1:0]  ba_ff, ba_in, bk_ff, bk_in;
   logic [8:0]  hash_ff [3][3], hash_in [3][3];
   wgt_type     w_ff [3][3], w_in [3][3];
   dwt_type     d_ff [3][3], d_in [3][3];

   // blend pipeline
   logic [1:0] p1x_ff, p1x_in, p1y_ff, p1y_in, p1z_ff, p1z_in;
   logic [1:0] pm1x_ff, pm1x_in, pm1y_ff, pm1y_in, pm1z_ff, pm1z_in;
   acc_type    pw_ff, pw_in, pd_ff, pd_in, aw_ff, aw_in, ad_ff, ad_in;
   logic [1:0] r1y_ff, r1y_in, r1z_ff, r1z_in;
   mid_type    axw_ff, axw_in, axd_ff, axd_in;
   logic [1:0] m2y_ff, m2y_in, m2z_ff, m2z_in;
   acc_type    qa_ff, qa_in, qb_ff, qb_in, qc_ff, qc_in;
   acc_type    a2a_ff, a2a_in, a2b_ff, a2b_in, a2c_ff, a2c_in;
   logic [1:0] r2z_ff, r2z_in;
   mid_type    aya_ff, aya_in, ayb_ff, ayb_in, ayc_ff, ayc_in;
   logic [1:0] m3z_ff, m3z_in;
   acc_type    ra_ff, ra_in, rb_ff, rb_in, rc_ff, rc_in, rd_ff, rd_in;
   acc_type    a3a_ff, a3a_in, a3b_ff, a3b_in, a3c_ff, a3c_in, a3d_ff, a3d_in;
   mid_type    s0_ff, s0_in, s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in;
   logic [15:0] noise_ff, noise_in;
   logic [17:0] gx_ff, gx_in, gy_ff, gy_in, gz_ff, gz_in;

   logic        acc_eval, acc_load, ram_we;
   logic [AW-1:0] ram_addr, rd_addr;
   logic [15:0] ram_rdata;
   logic [15:0] idx_ext;
   logic [31:0] fr_raw;
   logic [33:0] sq_raw;
   logic [40:0] hp;
   logic [8:0]  prime_sel;
   wgt_type     wsel, one_w, fqs, sqs;
   dwt_type     dsel, f18;
   logic signed [16:0] ev;
   logic signed [51:0] pw_raw;
   logic signed [34:0] pd_raw;
   logic signed [62:0] qa_raw, qb_raw, ra_raw, rb_raw, rc_raw;
   logic signed [45:0] qc_raw, rd_raw;
   acc_type     sw, sd, sa2, sb2, sc2, sa3, sb3, sc3, sd3;

   assign busy     = (state_ff != ST_IDLE);
   assign acc_eval = start && !busy && req_action;
   assign acc_load = start && !busy && !req_action;
   assign idx_ext  = 16'(req_entry_index);
   assign ram_we   = acc_load && (idx_ext < DEP);
   assign rd_addr  = wrap_idx(10'(hash_ff[0][rx_ff]) + 10'(hash_ff[1][ry_ff])
                              + 10'(hash_ff[2][rz_ff]));
   assign ram_addr = ram_we ? idx_ext[AW-1:0] : rd_addr;

   lvn_ram #(
      .WIDTH (16),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .we      (ram_we),
      .addr    (ram_addr),
      .wdata   (req_entry_value),
      .rd_data (ram_rdata)
   );

   // setup arithmetic
   assign fr_raw = (cell_ff[sa_ff] + 32'(sk_ff)) * PHI_Q32;
   assign sq_raw = 34'(fq_ff[sa_ff]) * 34'(fq_ff[sa_ff]);
   assign hp     = 41'(prime_sel) * 41'(fr_ff);
   assign one_w  = 35'sh1_0000_0000;
   assign fqs    = $signed(35'(fq_ff[ba_ff]));
   assign sqs    = $signed(35'(sq_ff));
   assign f18    = $signed(18'(fq_ff[ba_ff]));

   always_comb begin
      case (ba_ff)
         2'd0:    prime_sel = PRIME_X;
         2'd1:    prime_sel = PRIME_Y;
         default: prime_sel = PRIME_Z;
      endcase
      case (bk_ff)
         2'd0: begin
            wsel = one_w - (fqs <<< 17) + sqs;
            dsel = f18 - 18'sd65536;
         end
         2'd1: begin
            wsel = one_w + (fqs <<< 17) - (sqs <<< 1);
            dsel = 18'sd65536 - (f18 <<< 1);
         end
         default: begin
            wsel = sqs;
            dsel = f18;
         end
      endcase
   end

   // blend arithmetic
   assign ev     = $signed({1'b0, ram_rdata});
   assign pw_raw = ev * w_ff[0][p1x_ff];
   assign pd_raw = ev * d_ff[0][p1x_ff];
   assign qa_raw = axw_ff * w_ff[1][r1y_ff];
   assign qb_raw = axd_ff * w_ff[1][r1y_ff];
   assign qc_raw = axw_ff * d_ff[1][r1y_ff];
   assign ra_raw = aya_ff * w_ff[2][r2z_ff];
   assign rb_raw = ayb_ff * w_ff[2][r2z_ff];
   assign rc_raw = ayc_ff * w_ff[2][r2z_ff];
   assign rd_raw = aya_ff * d_ff[2][r2z_ff];

   assign sw  = ((pm1x_ff == 2'd0) ? acc_type'(0) : aw_ff) + pw_ff;
   assign sd  = ((pm1x_ff == 2'd0) ? acc_type'(0) : ad_ff) + pd_ff;
   assign sa2 = ((m2y_ff == 2'd0) ? acc_type'(0) : a2a_ff) + qa_ff;
   assign sb2 = ((m2y_ff == 2'd0) ? acc_type'(0) : a2b_ff) + qb_ff;
   assign sc2 = ((m2y_ff == 2'd0) ? acc_type'(0) : a2c_ff) + qc_ff;
   assign sa3 = ((m3z_ff == 2'd0) ? acc_type'(0) : a3a_ff) + ra_ff;
   assign sb3 = ((m3z_ff == 2'd0) ? acc_type'(0) : a3b_ff) + rb_ff;
   assign sc3 = ((m3z_ff == 2'd0) ? acc_type'(0) : a3c_ff) + rc_ff;
   assign sd3 = ((m3z_ff == 2'd0) ? acc_type'(0) : a3d_ff) + rd_ff;

   always_comb begin
      state_in = state_ff;
      sa_in    = sa_ff;
      sk_in    = sk_ff;
      bv_in    = 1'b0;
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      rz_in    = rz_ff;
      p1v_in   = 1'b0;
      cell_in  = cell_ff;
      fq_in    = fq_ff;
      fr_in    = fr_ff;
      sq_in    = sq_ff;
      ba_in    = ba_ff;
      bk_in    = bk_ff;
      hash_in  = hash_ff;
      w_in     = w_ff;
      d_in     = d_ff;
      p1x_in   = p1x_ff;
      p1y_in   = p1y_ff;
      p1z_in   = p1z_ff;

      case (state_ff)
         ST_IDLE: begin
            if (acc_eval) begin
               cell_in[0] = cell_of(req_pos_x);
               cell_in[1] = cell_of(req_pos_y);
               cell_in[2] = cell_of(req_pos_z);
               fq_in[0]   = frac_q(req_pos_x);
               fq_in[1]   = frac_q(req_pos_y);
               fq_in[2]   = frac_q(req_pos_z);
               sa_in      = 2'd0;
               sk_in      = 2'd0;
               rx_in      = 2'd0;
               ry_in      = 2'd0;
               rz_in      = 2'd0;
               state_in   = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (sa_ff == 2'd3) begin
               state_in = ST_READ;
            end else begin
               bv_in = 1'b1;
               ba_in = sa_ff;
               bk_in = sk_ff;
               fr_in = fr_raw;
               sq_in = sq_raw;
               if (sk_ff == 2'd2) begin
                  sk_in = 2'd0;
                  sa_in = sa_ff + 2'd1;
               end else begin
                  sk_in = sk_ff + 2'd1;
               end
            end
         end
         ST_READ: begin
            p1v_in = 1'b1;
            p1x_in = rx_ff;
            p1y_in = ry_ff;
            p1z_in = rz_ff;
            if (rx_ff == 2'd2) begin
               rx_in = 2'd0;
               if (ry_ff == 2'd2) begin
                  ry_in = 2'd0;
                  if (rz_ff == 2'd2) begin
                     state_in = ST_DRAIN;
                  end else begin
                     rz_in = rz_ff + 2'd1;
                  end
               end else begin
                  ry_in = ry_ff + 2'd1;
               end
            end else begin
               rx_in = rx_ff + 2'd1;
            end
         end
         ST_DRAIN: begin
            if (fv_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (bv_ff) begin
         hash_in[ba_ff][bk_ff] = hp[40:32];
         w_in[ba_ff][bk_ff]    = wsel;
         d_in[ba_ff][bk_ff]    = dsel;
      end
   end

   always_comb begin
      pm1v_in = p1v_ff;
      pm1x_in = p1x_ff;
      pm1y_in = p1y_ff;
      pm1z_in = p1z_ff;
      pw_in   = 64'(pw_raw);
      pd_in   = 64'(pd_raw);

      aw_in  = aw_ff;
      ad_in  = ad_ff;
      r1v_in = 1'b0;
      r1y_in = r1y_ff;
      r1z_in = r1z_ff;
      axw_in = axw_ff;
      axd_in = axd_ff;
      if (pm1v_ff) begin
         aw_in = sw;
         ad_in = sd;
         if (pm1x_ff == 2'd2) begin
            r1v_in = 1'b1;
            r1y_in = pm1y_ff;
            r1z_in = pm1z_ff;
            axw_in = 28'(rnd(sw, 25));
            axd_in = 28'(rnd(sd, 8));
         end
      end

      m2v_in = r1v_ff;
      m2y_in = r1y_ff;
      m2z_in = r1z_ff;
      qa_in  = 64'(qa_raw);
      qb_in  = 64'(qb_raw);
      qc_in  = 64'(qc_raw);

      a2a_in = a2a_ff;
      a2b_in = a2b_ff;
      a2c_in = a2c_ff;
      r2v_in = 1'b0;
      r2z_in = r2z_ff;
      aya_in = aya_ff;
      ayb_in = ayb_ff;
      ayc_in = ayc_ff;
      if (m2v_ff) begin
         a2a_in = sa2;
         a2b_in = sb2;
         a2c_in = sc2;
         if (m2y_ff == 2'd2) begin
            r2v_in = 1'b1;
            r2z_in = m2z_ff;
            aya_in = 28'(rnd(sa2, 33));
            ayb_in = 28'(rnd(sb2, 33));
            ayc_in = 28'(rnd(sc2, 16));
         end
      end

      m3v_in = r2v_ff;
      m3z_in = r2z_ff;
      ra_in  = 64'(ra_raw);
      rb_in  = 64'(rb_raw);
      rc_in  = 64'(rc_raw);
      rd_in  = 64'(rd_raw);

      a3a_in = a3a_ff;
      a3b_in = a3b_ff;
      a3c_in = a3c_ff;
      a3d_in = a3d_ff;
      fv_in  = 1'b0;
      s0_in  = s0_ff;
      s1_in  = s1_ff;
      s2_in  = s2_ff;
      s3_in  = s3_ff;
      if (m3v_ff) begin
         a3a_in = sa3;
         a3b_in = sb3;
         a3c_in = sc3;
         a3d_in = sd3;
         if (m3z_ff == 2'd2) begin
            fv_in = 1'b1;
            s0_in = 28'(rnd(sa3, 33));
            s1_in = 28'(rnd(sb3, 33));
            s2_in = 28'(rnd(sc3, 33));
            s3_in = 28'(rnd(sd3, 16));
         end
      end

      rsp_strobe_in = fv_ff;
      noise_in = noise_ff;
      gx_in    = gx_ff;
      gy_in    = gy_ff;
      gz_in    = gz_ff;
      if (fv_ff) begin
         noise_in = sat16(rnd(64'(s0_ff), 8));
         gx_in    = sat18(rnd(64'(s1_ff), 8));
         gy_in    = sat18(rnd(64'(s2_ff), 8));
         gz_in    = sat18(rnd(64'(s3_ff), 8));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sa_ff         <= 2'd0;
         sk_ff         <= 2'd0;
         bv_ff         <= 1'b0;
         rx_ff         <= 2'd0;
         ry_ff         <= 2'd0;
         rz_ff         <= 2'd0;
         p1v_ff        <= 1'b0;
         pm1v_ff       <= 1'b0;
         r1v_ff        <= 1'b0;
         m2v_ff        <= 1'b0;
         r2v_ff        <= 1'b0;
         m3v_ff        <= 1'b0;
         fv_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sa_ff         <= sa_in;
         sk_ff         <= sk_in;
         bv_ff         <= bv_in;
         rx_ff         <= rx_in;
         ry_ff         <= ry_in;
         rz_ff         <= rz_in;
         p1v_ff        <= p1v_in;
         pm1v_ff       <= pm1v_in;
         r1v_ff        <= r1v_in;
         m2v_ff        <= m2v_in;
         r2v_ff        <= r2v_in;
         m3v_ff        <= m3v_in;
         fv_ff         <= fv_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff  <= cell_in;
      fq_ff    <= fq_in;
      fr_ff    <= fr_in;
      sq_ff    <= sq_in;
      ba_ff    <= ba_in;
      bk_ff    <= bk_in;
      hash_ff  <= hash_in;
      w_ff     <= w_in;
      d_ff     <= d_in;
      p1x_ff   <= p1x_in;
      p1y_ff   <= p1y_in;
      p1z_ff   <= p1z_in;
      pm1x_ff  <= pm1x_in;
      pm1y_ff  <= pm1y_in;
      pm1z_ff  <= pm1z_in;
      pw_ff    <= pw_in;
      pd_ff    <= pd_in;
      aw_ff    <= aw_in;
      ad_ff    <= ad_in;
      r1y_ff   <= r1y_in;
      r1z_ff   <= r1z_in;
      axw_ff   <= axw_in;
      axd_ff   <= axd_in;
      m2y_ff   <= m2y_in;
      m2z_ff   <= m2z_in;
      qa_ff    <= qa_in;
      qb_ff    <= qb_in;
      qc_ff    <= qc_in;
      a2a_ff   <= a2a_in;
      a2b_ff   <= a2b_in;
      a2c_ff   <= a2c_in;
      r2z_ff   <= r2z_in;
      aya_ff   <= aya_in;
      ayb_ff   <= ayb_in;
      ayc_ff   <= ayc_in;
      m3z_ff   <= m3z_in;
      ra_ff    <= ra_in;
      rb_ff    <= rb_in;
      rc_ff    <= rc_in;
      rd_ff    <= rd_in;
      a3a_ff   <= a3a_in;
      a3b_ff   <= a3b_in;
      a3c_ff   <= a3c_in;
      a3d_ff   <= a3d_in;
      s0_ff    <= s0_in;
      s1_ff    <= s1_in;
      s2_ff    <= s2_in;
      s3_ff    <= s3_in;
      noise_ff <= noise_in;
      gx_ff    <= gx_in;
      gy_ff    <= gy_in;
      gz_ff    <= gz_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_noise_value = noise_ff;
   assign rsp_grad_x      = $signed(gx_ff);
   assign rsp_grad_y      = $signed(gy_ff);
   assign rsp_grad_z      = $signed(gz_ff);
endmodule
